/* design/rbd_pkg.sv */
package rbd_pkg;

  localparam int DEPTH_DEF = 256;
  localparam int WIDTH_DEF = 32;

  localparam int CMD_W    = 3;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 3'd0,
    CMD_PREPEND = 3'd1,
    CMD_SHIFT   = 3'd2,
    CMD_POP     = 3'd3,
    CMD_READ_AT = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

/* design/rbd_if.sv */
interface rbd_in_if #(
  parameter int WIDTH = rbd_pkg::WIDTH_DEF
);
  logic                       valid;
  logic                       ready;
  logic [rbd_pkg::CMD_W-1:0]  cmd;
  logic [WIDTH-1:0]           data_in;
  logic [rbd_pkg::POS_W-1:0]  position;

  modport source (output valid, output cmd, output data_in, output position, input ready);
  modport sink   (input valid, input cmd, input data_in, input position, output ready);
endinterface

interface rbd_out_if #(
  parameter int WIDTH   = rbd_pkg::WIDTH_DEF,
  parameter int COUNT_W = $clog2(rbd_pkg::DEPTH_DEF + 1)
);
  logic                         valid;
  logic                         ready;
  logic [WIDTH-1:0]             data_out;
  logic [rbd_pkg::STATUS_W-1:0] status;
  logic [COUNT_W-1:0]           count;

  modport source (output valid, output data_out, output status, output count, input ready);
  modport sink   (input valid, input data_out, input status, input count, output ready);
endinterface

/* design/rbd_ram.sv */
module rbd_ram #(
  parameter int WIDTH = rbd_pkg::WIDTH_DEF,
  parameter int DEPTH = rbd_pkg::DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/ring_buffer_deque.sv */
// Channel  Direction  Payload                        Handshake
// in_ch    input      cmd, data_in, position         valid / ready
// out_ch   output     data_out, status, count        valid / ready
//
// One command item is taken per cycle while the result stage is not stalled; its result is presented in the next cycle.
// This follows from the registered read port of the element store.
// Reset is synchronous and clears the pointers, the fill and the result valid flag.
// A stalled result holds the result stage, and no new item is taken until it leaves.
module ring_buffer_deque #(
  parameter int DEPTH = rbd_pkg::DEPTH_DEF,
  parameter int WIDTH = rbd_pkg::WIDTH_DEF
) (
  input logic clk,
  input logic rst_n,
  rbd_in_if.sink    in_ch,
  rbd_out_if.source out_ch
);
  import rbd_pkg::*;

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W   = (COUNT_W > POS_W) ? COUNT_W : POS_W;

  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt;
  logic [COUNT_W-1:0] fill_r, fill_nxt;

  logic               res_valid_r;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [COUNT_W-1:0] res_count_r;
  logic               res_rd_r, res_rd_nxt;

  logic               accept;
  logic               full;
  logic               empty;
  logic               wr_en;
  logic [PTR_W-1:0]   wr_addr;
  logic               rd_en;
  logic [PTR_W-1:0]   rd_addr;
  logic [WIDTH-1:0]   rd_data;

  logic [PTR_W-1:0]   head_inc, head_dec, tail_inc, tail_dec;
  logic [PTR_W:0]     sum_idx;
  logic [PTR_W-1:0]   read_idx;
  logic               pos_bad;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !res_valid_r || out_ch.ready;

  assign full  = (fill_r == COUNT_W'(DEPTH));
  assign empty = (fill_r == '0);

  assign head_inc = (head_r == PTR_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? PTR_W'(DEPTH - 1) : head_r - 1'b1;
  assign tail_inc = (tail_r == PTR_W'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign tail_dec = (tail_r == '0) ? PTR_W'(DEPTH - 1) : tail_r - 1'b1;

  // A valid position is below the fill, so the sum stays under twice the depth.
  assign pos_bad  = (CMP_W'(in_ch.position) >= CMP_W'(fill_r));
  assign sum_idx  = {1'b0, head_r} + (PTR_W + 1)'(in_ch.position);
  assign read_idx = (sum_idx >= (PTR_W + 1)'(DEPTH)) ?
                    PTR_W'(sum_idx - (PTR_W + 1)'(DEPTH)) : sum_idx[PTR_W-1:0];

  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    fill_nxt       = fill_r;
    res_status_nxt = ST_OK;
    res_rd_nxt     = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = tail_r;
    rd_en          = 1'b0;
    rd_addr        = head_r;
    case (in_ch.cmd)
      CMD_APPEND: begin
        if (full) begin
          res_status_nxt = ST_FULL;
        end else begin
          wr_en    = accept;
          wr_addr  = tail_r;
          tail_nxt = tail_inc;
          fill_nxt = fill_r + 1'b1;
        end
      end
      CMD_PREPEND: begin
        if (full) begin
          res_status_nxt = ST_FULL;
        end else begin
          wr_en    = accept;
          wr_addr  = head_dec;
          head_nxt = head_dec;
          fill_nxt = fill_r + 1'b1;
        end
      end
      CMD_SHIFT: begin
        if (empty) begin
          res_status_nxt = ST_EMPTY;
        end else begin
          rd_en      = accept;
          rd_addr    = head_r;
          res_rd_nxt = 1'b1;
          head_nxt   = head_inc;
          fill_nxt   = fill_r - 1'b1;
        end
      end
      CMD_POP: begin
        if (empty) begin
          res_status_nxt = ST_EMPTY;
        end else begin
          rd_en      = accept;
          rd_addr    = tail_dec;
          res_rd_nxt = 1'b1;
          tail_nxt   = tail_dec;
          fill_nxt   = fill_r - 1'b1;
        end
      end
      CMD_READ_AT: begin
        if (pos_bad) begin
          res_status_nxt = ST_EMPTY;
        end else begin
          rd_en      = accept;
          rd_addr    = read_idx;
          res_rd_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        head_r      <= head_nxt;
        tail_r      <= tail_nxt;
        fill_r      <= fill_nxt;
        res_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_status_r <= res_status_nxt;
      res_count_r  <= fill_nxt;
      res_rd_r     <= res_rd_nxt;
    end
  end

  rbd_ram #(
    .WIDTH (WIDTH),
    .DEPTH (DEPTH),
    .ADDR_W(PTR_W)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(in_ch.data_in),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  assign out_ch.valid    = res_valid_r;
  assign out_ch.data_out = res_rd_r ? rd_data : '0;
  assign out_ch.status   = res_status_r;
  assign out_ch.count    = res_count_r;

endmodule
